// ===== src/adv_manufacturer_data_detector_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the advertising data detector
// Shorthand for clocked implication checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ADV_MANUFACTURER_DATA_DETECTOR_MACROS_SVH
`define ADV_MANUFACTURER_DATA_DETECTOR_MACROS_SVH

// same-cycle implication
`define ADM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adm check failed");

// next-cycle implication
`define ADM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adm check failed");

`endif

// ===== src/adm_pkg.sv =====
// ---------------------------------------------------------------------------
// adm_pkg
// Shared types and constants of the advertising data detector.
// ---------------------------------------------------------------------------
package adm_pkg;

    localparam int CMD_BITS       = 2;
    localparam int BYTE_BITS      = 8;
    localparam int ID_BITS        = 16;
    localparam int TICKS_BITS     = 32;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 4;
    localparam int HOLD_BITS_DEF  = 32;
    localparam int HEAD_DEPTH     = 4;
    localparam int HEAD_IDX_BITS  = $clog2(HEAD_DEPTH);
    localparam int COUNT_BITS     = HEAD_IDX_BITS + 1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_BYTE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_POWER = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_MATCH_TYPE = 2'd0,
        REG_SIGNATURE  = 2'd1,
        REG_ACTIVE_ID  = 2'd2,
        REG_HOLD_TICKS = 2'd3
    } reg_idx_t;

    localparam logic [BYTE_BITS-1:0]  MATCH_TYPE_RST = 8'hFF;
    localparam logic [ID_BITS-1:0]    SIGNATURE_RST  = 16'h0603;
    localparam logic [ID_BITS-1:0]    ACTIVE_ID_RST  = 16'hAAFD;
    localparam logic [TICKS_BITS-1:0] HOLD_TICKS_RST = 32'd1000000;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  match_ad_type;
        logic [ID_BITS-1:0]    device_signature;
        logic [ID_BITS-1:0]    active_identifier;
        logic [TICKS_BITS-1:0] hold_ticks;
    } adm_cfg_t;

endpackage

// ===== src/adm_in_if.sv =====
// ---------------------------------------------------------------------------
// adm_in_if
// Input word channel: command, advertisement byte and end marker.
// ---------------------------------------------------------------------------
interface adm_in_if;
    logic                           valid;
    logic                           ready;
    logic [adm_pkg::CMD_BITS-1:0]   command;
    logic [adm_pkg::BYTE_BITS-1:0]  data_byte;
    logic                           end_of_advert;

    modport source (output valid, command, data_byte, end_of_advert, input ready);
    modport sink   (input valid, command, data_byte, end_of_advert, output ready);
endinterface

// ===== src/adm_out_if.sv =====
// ---------------------------------------------------------------------------
// adm_out_if
// Result word channel: flags after each input word.
// ---------------------------------------------------------------------------
interface adm_out_if;
    logic valid;
    logic ready;
    logic power_on;
    logic connected;
    logic advert_done;
    logic advert_sighting;
    logic advert_active;
    logic hold_running;

    modport source (output valid, power_on, connected, advert_done, advert_sighting,
                    advert_active, hold_running, input ready);
    modport sink   (input valid, power_on, connected, advert_done, advert_sighting,
                    advert_active, hold_running, output ready);
endinterface

// ===== src/adm_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// adm_cfg_regs
// APB register file holding match type, signature, identifier and hold time.
// ---------------------------------------------------------------------------
module adm_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [adm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [adm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output adm_pkg::adm_cfg_t                  cfg
);
    import adm_pkg::*;

    adm_cfg_t cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_ad_type     <= MATCH_TYPE_RST;
            cfg_reg.device_signature  <= SIGNATURE_RST;
            cfg_reg.active_identifier <= ACTIVE_ID_RST;
            cfg_reg.hold_ticks        <= HOLD_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MATCH_TYPE: cfg_reg.match_ad_type     <= pwdata[BYTE_BITS-1:0];
                REG_SIGNATURE:  cfg_reg.device_signature  <= pwdata[ID_BITS-1:0];
                REG_ACTIVE_ID:  cfg_reg.active_identifier <= pwdata[ID_BITS-1:0];
                REG_HOLD_TICKS: cfg_reg.hold_ticks        <= pwdata[TICKS_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MATCH_TYPE: prdata = APB_DATA_BITS'(cfg_reg.match_ad_type);
            REG_SIGNATURE:  prdata = APB_DATA_BITS'(cfg_reg.device_signature);
            REG_ACTIVE_ID:  prdata = APB_DATA_BITS'(cfg_reg.active_identifier);
            REG_HOLD_TICKS: prdata = APB_DATA_BITS'(cfg_reg.hold_ticks);
        endcase
    end

endmodule

// ===== src/adv_manufacturer_data_detector.sv =====
// Path: an accepted word is held in the input register, and its result word in the
// result register. Throughput: one word per cycle while the sink takes results;
// input register, one parser/timer update step, result register (the skid stage
// toward the sink). Reset: rst_n clears parser, power/connected flags, hold counter
// and valids, loads config defaults; payload head bytes and result flags are not reset.
// ---------------------------------------------------------------------------
// adv_manufacturer_data_detector
// Walks advertising length-type-value structures, flags device and active
// sightings, and runs the retriggerable power-on hold counter.
// ---------------------------------------------------------------------------
`include "adv_manufacturer_data_detector_macros.svh"

module adv_manufacturer_data_detector #(
    parameter int HOLD_BITS = adm_pkg::HOLD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    adm_in_if.sink                             adv,
    adm_out_if.source                          res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [adm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [adm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import adm_pkg::*;

    localparam int EXT_BITS = (HOLD_BITS > TICKS_BITS) ? HOLD_BITS : TICKS_BITS;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_STOPPED = 2'd3
    } phase_t;

    adm_cfg_t cfg;

    adm_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage
    logic                  s1_valid_reg;
    cmd_t                  s1_cmd_reg;
    logic [BYTE_BITS-1:0]  s1_byte_reg;
    logic                  s1_last_reg;

    // parser and timer state
    phase_t                phase_reg, phase_next;
    logic [BYTE_BITS-1:0]  left_reg, left_next;
    logic [BYTE_BITS-1:0]  stype_reg, stype_next;
    logic [COUNT_BITS-1:0] pcount_reg, pcount_next;
    logic [BYTE_BITS-1:0]  head_reg [HEAD_DEPTH];
    logic [BYTE_BITS-1:0]  head_next [HEAD_DEPTH];
    logic                  sight_seen_reg, sight_seen_next;
    logic                  act_seen_reg, act_seen_next;
    logic                  power_reg, power_next;
    logic                  conn_reg, conn_next;
    logic [HOLD_BITS-1:0]  hold_reg, hold_next;

    // result stage
    logic                  res_valid_reg;
    logic                  done_reg, done_next;
    logic                  rsight_reg, rsight_next;
    logic                  ract_reg, ract_next;
    logic                  running_reg;

    logic                  advance;
    logic                  fire;
    logic                  finish;
    logic [ID_BITS-1:0]    sig_word;
    logic [ID_BITS-1:0]    act_word;
    logic [EXT_BITS-1:0]   ticks_ext;
    logic [EXT_BITS-1:0]   hold_max_ext;
    logic [HOLD_BITS-1:0]  reload;

    assign advance   = !res_valid_reg || res.ready;
    assign fire      = s1_valid_reg && advance;
    assign adv.ready = !s1_valid_reg || advance;

    // reload value: saturate to counter width, zero counts as one tick
    assign ticks_ext    = EXT_BITS'(cfg.hold_ticks);
    assign hold_max_ext = EXT_BITS'({HOLD_BITS{1'b1}});

    always_comb
    begin
        if (ticks_ext > hold_max_ext)
            reload = '1;
        else
            reload = HOLD_BITS'(ticks_ext);
        if (reload == '0)
            reload = HOLD_BITS'(1);
    end

    assign sig_word = {head_next[3], head_next[2]};
    assign act_word = {head_next[1], head_next[0]};

    always_comb
    begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        stype_next      = stype_reg;
        pcount_next     = pcount_reg;
        head_next       = head_reg;
        sight_seen_next = sight_seen_reg;
        act_seen_next   = act_seen_reg;
        power_next      = power_reg;
        conn_next       = conn_reg;
        hold_next       = hold_reg;
        done_next       = 1'b0;
        rsight_next     = 1'b0;
        ract_next       = 1'b0;
        finish          = 1'b0;

        unique case (s1_cmd_reg)
            CMD_BYTE:
            begin
                unique case (phase_reg)
                    PH_LENGTH:
                    begin
                        if (s1_byte_reg == '0)
                            phase_next = PH_STOPPED;
                        else
                        begin
                            left_next  = s1_byte_reg;
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        stype_next  = s1_byte_reg;
                        pcount_next = '0;
                        left_next   = left_reg - BYTE_BITS'(1);
                        if (left_next == '0)
                        begin
                            finish     = 1'b1;
                            phase_next = PH_LENGTH;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        if (!pcount_reg[COUNT_BITS-1])
                        begin
                            head_next[pcount_reg[HEAD_IDX_BITS-1:0]] = s1_byte_reg;
                            pcount_next = pcount_reg + COUNT_BITS'(1);
                        end
                        left_next = left_reg - BYTE_BITS'(1);
                        if (left_next == '0)
                        begin
                            finish     = 1'b1;
                            phase_next = PH_LENGTH;
                        end
                    end
                    PH_STOPPED:
                    begin
                    end
                endcase

                if (finish && stype_next == cfg.match_ad_type
                    && pcount_next[COUNT_BITS-1] && sig_word == cfg.device_signature)
                begin
                    sight_seen_next = 1'b1;
                    if (act_word == cfg.active_identifier)
                        act_seen_next = 1'b1;
                end

                if (s1_last_reg)
                begin
                    done_next   = 1'b1;
                    rsight_next = sight_seen_next;
                    ract_next   = act_seen_next;
                    if (sight_seen_next)
                        conn_next = 1'b1;
                    if (act_seen_next)
                    begin
                        power_next = 1'b1;
                        hold_next  = reload;
                    end
                    phase_next      = PH_LENGTH;
                    left_next       = '0;
                    pcount_next     = '0;
                    sight_seen_next = 1'b0;
                    act_seen_next   = 1'b0;
                end
            end
            CMD_TICK:
            begin
                if (hold_reg != '0)
                begin
                    hold_next = hold_reg - HOLD_BITS'(1);
                    if (hold_next == '0)
                        power_next = 1'b0;
                end
            end
            CMD_POWER:
            begin
                power_next = 1'b1;
                conn_next  = 1'b1;
                hold_next  = reload;
            end
            CMD_NONE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            phase_reg      <= PH_LENGTH;
            left_reg       <= '0;
            stype_reg      <= '0;
            pcount_reg     <= '0;
            sight_seen_reg <= 1'b0;
            act_seen_reg   <= 1'b0;
            power_reg      <= 1'b0;
            conn_reg       <= 1'b0;
            hold_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv.ready)
                s1_valid_reg <= adv.valid;
            if (advance)
                res_valid_reg <= s1_valid_reg;
            if (fire)
            begin
                phase_reg      <= phase_next;
                left_reg       <= left_next;
                stype_reg      <= stype_next;
                pcount_reg     <= pcount_next;
                sight_seen_reg <= sight_seen_next;
                act_seen_reg   <= act_seen_next;
                power_reg      <= power_next;
                conn_reg       <= conn_next;
                hold_reg       <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.valid && adv.ready)
        begin
            s1_cmd_reg  <= cmd_t'(adv.command);
            s1_byte_reg <= adv.data_byte;
            s1_last_reg <= adv.end_of_advert;
        end
        if (fire)
        begin
            head_reg    <= head_next;
            done_reg    <= done_next;
            rsight_reg  <= rsight_next;
            ract_reg    <= ract_next;
            running_reg <= (hold_next != '0);
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.power_on        = power_reg;
    assign res.connected       = conn_reg;
    assign res.advert_done     = done_reg;
    assign res.advert_sighting = rsight_reg;
    assign res.advert_active   = ract_reg;
    assign res.hold_running    = running_reg;

    `ADM_ASSERT_IMP(a_active_implies_sighting, res.valid && res.advert_active, res.advert_sighting)
    `ADM_ASSERT_IMP(a_sighting_implies_done, res.valid && res.advert_sighting, res.advert_done)
    `ADM_ASSERT_IMP(a_hold_implies_power, hold_reg != '0, power_reg)
    `ADM_ASSERT_NXT(a_connected_sticky, conn_reg, conn_reg)
    `ADM_ASSERT_NXT(a_stage_held_on_stall, s1_valid_reg && !advance, s1_valid_reg)

endmodule
